// ===== design/sbct_pkg.sv =====
package sbct_pkg;

  // coordinate and time formats
  localparam int CW      = 32;            // signed coordinate width, Q16.16
  localparam int TFB     = 16;            // fraction bits of a time
  localparam int TW      = TFB + 1;       // time width, holds 1.0
  localparam int NS      = TFB;           // divider stages, one quotient bit each
  localparam int NST     = NS + 3;        // capture, prep, divider, output
  localparam int NFLD_IN = 12;
  localparam int IN_W    = ((NFLD_IN * CW + 7) / 8) * 8;
  localparam int OUT_RAW = 1 + 2 * TW + 4;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [TW-1:0] T_ONE  = TW'(1) << TFB;
  localparam logic [TW-1:0] T_OVER = T_ONE + TW'(1);

  // normal component codes, two's complement
  localparam logic [1:0] N_ZERO = 2'b00;
  localparam logic [1:0] N_POS  = 2'b01;
  localparam logic [1:0] N_NEG  = 2'b11;

  // quotient class decided before the bit iterations
  typedef enum logic [1:0] {
    QC_DIV  = 2'b00,
    QC_ZERO = 2'b01,
    QC_ONE  = 2'b10,
    QC_OVER = 2'b11
  } qcls_t;

  typedef struct packed {
    logic ov;      // intervals overlap at time zero
    logic rej;     // axis alone rules out contact
    logic vzero;   // no relative motion
    logic vpos;    // relative motion positive
  } lflag_t;

  typedef struct packed {
    lflag_t          f;
    logic [TW-1:0]   ent;   // entry time, zero when none
    logic [TW-1:0]   ext;   // exit time, 1.0 when none
    logic [TW-1:0]   tov;   // exit time used on initial overlap
  } lane_res_t;

endpackage

// ===== design/sbct_div.sv =====
module sbct_div
  import sbct_pkg::*;
(
  input  logic                 clk,
  input  logic [NS-1:0]        en,
  input  logic signed [CW:0]   num,
  input  logic [CW:0]          den,
  output logic [TW-1:0]        quo
);

  logic [CW:0]    r_s [NS];
  logic [CW:0]    d_s [NS];
  logic [TFB-1:0] q_s [NS];
  qcls_t          c_s [NS];

  logic [CW:0]    ri [NS];
  logic [CW:0]    di [NS];
  logic [TFB-1:0] qi [NS];
  qcls_t          ci [NS];
  logic [CW+1:0]  r2 [NS];
  logic [CW+1:0]  rs [NS];
  logic [NS-1:0]  ge;

  logic [CW:0]    num_mag;
  qcls_t          cls0;

  assign num_mag = num;

  // saturation classes
  always_comb begin
    priority if (num[CW] || num == '0) cls0 = QC_ZERO;
    else if (num_mag > den)            cls0 = QC_OVER;
    else if (num_mag == den)           cls0 = QC_ONE;
    else                               cls0 = QC_DIV;
  end

  // one restoring step per stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        ri[k] = num_mag;
        di[k] = den;
        qi[k] = '0;
        ci[k] = cls0;
      end else begin
        ri[k] = r_s[k-1];
        di[k] = d_s[k-1];
        qi[k] = q_s[k-1];
        ci[k] = c_s[k-1];
      end
      r2[k] = {ri[k], 1'b0};
      ge[k] = r2[k] >= {1'b0, di[k]};
      rs[k] = r2[k] - {1'b0, di[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        r_s[k] <= ge[k] ? rs[k][CW:0] : r2[k][CW:0];
        d_s[k] <= di[k];
        q_s[k] <= {qi[k][TFB-2:0], ge[k]};
        c_s[k] <= ci[k];
      end
    end
  end

  always_comb begin
    unique case (c_s[NS-1])
      QC_ZERO: quo = '0;
      QC_ONE:  quo = T_ONE;
      QC_OVER: quo = T_OVER;
      QC_DIV:  quo = {1'b0, q_s[NS-1]};
      default: quo = '0;
    endcase
  end

endmodule

// ===== design/sbct_axis.sv =====
module sbct_axis
  import sbct_pkg::*;
(
  input  logic                 clk,
  input  logic [NS+1:0]        en,
  input  logic signed [CW-1:0] amin,
  input  logic signed [CW-1:0] amax,
  input  logic signed [CW-1:0] bmin,
  input  logic signed [CW-1:0] bmax,
  input  logic signed [CW-1:0] va,
  input  logic signed [CW-1:0] vb,
  output lane_res_t            res
);

  typedef struct packed {
    lflag_t f;
    logic   has_e;
    logic   has_x;
  } pflag_t;

  logic signed [CW-1:0] amin_r, amax_r, bmin_r, bmax_r, va_r, vb_r;
  logic signed [CW:0]   d1, d2, v;
  logic signed [CW:0]   ne, nx;
  logic [CW:0]          den;
  logic                 d1n, d2n, d1z, d2z, vneg, vzero, vpos;
  pflag_t               pf;

  logic signed [CW:0]   ne_r, nx_r;
  logic [CW:0]          den_r;
  pflag_t               pf_r;
  pflag_t               pf_s [NS];
  logic [TW-1:0]        te, tx;

  // item capture
  always_ff @(posedge clk) begin
    if (en[0]) begin
      amin_r <= amin;
      amax_r <= amax;
      bmin_r <= bmin;
      bmax_r <= bmax;
      va_r   <= va;
      vb_r   <= vb;
    end
  end

  // gaps, relative velocity and the two divisions to run
  always_comb begin
    d1    = {bmax_r[CW-1], bmax_r} - {amin_r[CW-1], amin_r};
    d2    = {amax_r[CW-1], amax_r} - {bmin_r[CW-1], bmin_r};
    v     = {vb_r[CW-1], vb_r} - {va_r[CW-1], va_r};
    d1n   = d1[CW];
    d2n   = d2[CW];
    d1z   = d1 == '0;
    d2z   = d2 == '0;
    vneg  = v[CW];
    vzero = v == '0;
    vpos  = !vneg && !vzero;
    den   = vneg ? $unsigned(-v) : $unsigned(v);
    ne    = vneg ? -d2 : -d1;
    nx    = vneg ? d1 : d2;
    pf.f.ov    = !d1n && !d2n;
    pf.f.rej   = vneg ? d1n : (vpos ? d2n : (d1n || d2n));
    pf.f.vzero = vzero;
    pf.f.vpos  = vpos;
    pf.has_e   = vneg ? d2n : (vpos ? d1n : 1'b0);
    pf.has_x   = vneg ? (!d1n && !d1z) : (vpos ? (!d2n && !d2z) : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ne_r  <= ne;
      nx_r  <= nx;
      den_r <= den;
      pf_r  <= pf;
    end
  end

  // flags ride along the divider stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k+2]) pf_s[k] <= (k == 0) ? pf_r : pf_s[k-1];
    end
  end

  sbct_div u_div_ent (
    .clk (clk),
    .en  (en[NS+1:2]),
    .num (ne_r),
    .den (den_r),
    .quo (te)
  );

  sbct_div u_div_ext (
    .clk (clk),
    .en  (en[NS+1:2]),
    .num (nx_r),
    .den (den_r),
    .quo (tx)
  );

  // exit beyond the step counts as the end of the step
  always_comb begin
    res.f   = pf_s[NS-1].f;
    res.ent = pf_s[NS-1].has_e ? te : '0;
    res.ext = (pf_s[NS-1].has_x && tx < T_ONE) ? tx : T_ONE;
    res.tov = pf_s[NS-1].f.vzero ? '0 : tx;
  end

endmodule

// ===== design/sbct_merge.sv =====
module sbct_merge
  import sbct_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  lane_res_t          lx,
  input  lane_res_t          ly,
  output logic [OUT_RAW-1:0] data
);

  logic          hit;
  logic [TW-1:0] tf, tl;
  logic [1:0]    nx, ny;

  // combine the two axis lanes
  always_comb begin
    hit = 1'b0;
    tf  = '0;
    tl  = '0;
    nx  = N_ZERO;
    ny  = N_ZERO;
    priority if (lx.f.ov && ly.f.ov) begin
      hit = 1'b1;
      if (ly.tov > lx.tov) ny = ly.f.vpos ? N_NEG : N_POS;
      else                 nx = lx.f.vpos ? N_NEG : N_POS;
    end else if (lx.f.vzero && ly.f.vzero) begin
      hit = 1'b0;
    end else begin
      tf  = (ly.ent > lx.ent) ? ly.ent : lx.ent;
      tl  = (ly.ext < lx.ext) ? ly.ext : lx.ext;
      hit = !lx.f.rej && !ly.f.rej && !(tf > tl);
      if (!hit) begin
        tf = '0;
        tl = '0;
      end else if (ly.ent > lx.ent) begin
        ny = ly.f.vpos ? N_NEG : N_POS;
      end else if (lx.ent != '0) begin
        nx = lx.f.vpos ? N_NEG : N_POS;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) data <= {ny, nx, tl, tf, hit};
  end

endmodule

// ===== design/swept_box_collision_test_top.sv =====
// Swept 2D box test: each transaction carries two boxes and their velocities
// in signed Q16.16; the result says whether they touch within one step, with
// first and last contact times (Q1.16, 1.0 = 65536) and a unit contact normal.
// One x lane and one y lane each run two 16-stage restoring dividers (entry and
// exit time) side by side, and a merge stage combines them. A new pair is taken
// every cycle unless the output stalls. The stages are capture, prep, 16 divider
// stages and output. Empty pipeline slots close up while the output waits, so
// input is still accepted until every stage holds a result.
module swept_box_collision_test_top
  import sbct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // a_min_x, a_min_y, a_max_x, a_max_y, b_min_x, b_min_y, b_max_x, b_max_y,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // hit, first_contact, last_contact, normal_x, normal_y, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  logic [NST-1:0]     vld;
  logic [NST-1:0]     en;
  lane_res_t          res_x, res_y;
  logic [OUT_RAW-1:0] mdata;

  // stage enables: a stage moves when empty or when the next one moves
  assign en[NST-1] = !vld[NST-1] || m_tready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) vld[k] <= (k == 0) ? s_tvalid : vld[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NST-1];
  assign m_tdata  = OUT_W'(mdata);

  sbct_axis u_lane_x (
    .clk  (clk),
    .en   (en[NS+1:0]),
    .amin (s_tdata[0*CW +: CW]),
    .amax (s_tdata[2*CW +: CW]),
    .bmin (s_tdata[4*CW +: CW]),
    .bmax (s_tdata[6*CW +: CW]),
    .va   (s_tdata[8*CW +: CW]),
    .vb   (s_tdata[10*CW +: CW]),
    .res  (res_x)
  );

  sbct_axis u_lane_y (
    .clk  (clk),
    .en   (en[NS+1:0]),
    .amin (s_tdata[1*CW +: CW]),
    .amax (s_tdata[3*CW +: CW]),
    .bmin (s_tdata[5*CW +: CW]),
    .bmax (s_tdata[7*CW +: CW]),
    .va   (s_tdata[9*CW +: CW]),
    .vb   (s_tdata[11*CW +: CW]),
    .res  (res_y)
  );

  sbct_merge u_merge (
    .clk  (clk),
    .en   (en[NST-1]),
    .lx   (res_x),
    .ly   (res_y),
    .data (mdata)
  );

`ifndef ASSERT_OFF
  // a miss carries no times and no normal
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_RAW-1:1] == '0)
    else $error("miss result with nonzero fields");

  // contact interval is ordered
  a_time_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[TW:1] <= m_tdata[2*TW:TW+1])
    else $error("first contact after last contact");

  // a later entry always sets exactly one normal axis
  a_entry_axis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && m_tdata[TW:1] != '0 |->
      $onehot({m_tdata[2*TW+4:2*TW+3] != N_ZERO, m_tdata[2*TW+2:2*TW+1] != N_ZERO}))
    else $error("bad contact normal");
`endif

endmodule
